### hw/rtl/apbc_pkg.sv
// apbc_pkg: shared types and constants for the ARGB pixel blit compositor.
// No dependencies; every other file imports it.

package apbc_pkg;

    localparam int PIX_W  = 32;
    localparam int CHAN_W = 8;
    localparam int NUM_CH = PIX_W / CHAN_W;
    localparam int MODE_W = 2;

    localparam logic [CHAN_W-1:0]   CHAN_MAX   = 8'hFF;
    localparam logic [2*CHAN_W-1:0] HALF_UNIT  = 16'h0080;
    localparam logic [PIX_W-1:0]    ALPHA_MASK = 32'hFF00_0000;
    localparam logic [PIX_W-1:0]    RGB_MASK   = 32'h00FF_FFFF;

    typedef enum logic [MODE_W-1:0] {
        MODE_COPY  = 2'd0,
        MODE_RGB   = 2'd1,
        MODE_ALPHA = 2'd2,
        MODE_OVER  = 2'd3
    } blend_mode_t;

    // Result of one blend: new pixel plus destination write strobe.
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             write_enable;
    } blend_res_t;

endpackage

### hw/rtl/apbc_if.sv
// Request and response channel interfaces for the blit compositor.
// Depends on apbc_pkg for the pixel width.

interface apbc_req_if import apbc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] src_pixel;
    logic [PIX_W-1:0] dst_pixel;

    modport source (output valid, output src_pixel, output dst_pixel, input ready);
    modport sink   (input valid, input src_pixel, input dst_pixel, output ready);
endinterface

interface apbc_rsp_if import apbc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] out_pixel;
    logic             write_enable;

    modport source (output valid, output out_pixel, output write_enable, input ready);
    modport sink   (input valid, input out_pixel, input write_enable, output ready);
endinterface

### hw/rtl/apbc_over_chan.sv
// apbc_over_chan: one 8-bit channel of premultiplied "over".
// Depends on apbc_pkg.

module apbc_over_chan import apbc_pkg::*; (
    input  logic [CHAN_W-1:0] src_c,
    input  logic [CHAN_W-1:0] dst_c,
    input  logic [CHAN_W-1:0] inv_alpha,
    output logic [CHAN_W-1:0] res_c
);

    logic [2*CHAN_W-1:0] prod;
    logic [2*CHAN_W:0]   acc;
    logic [CHAN_W:0]     scaled;
    logic [CHAN_W:0]     sum;

    // src + dst * (255 - srcA) / 255, rounded, saturated at 255
    always_comb
    begin
        prod   = dst_c * inv_alpha + HALF_UNIT;
        acc    = {1'b0, prod} + {{(CHAN_W+1){1'b0}}, prod[2*CHAN_W-1:CHAN_W]};
        scaled = acc[2*CHAN_W:CHAN_W];
        sum    = {1'b0, src_c} + scaled;
        res_c  = sum[CHAN_W] ? CHAN_MAX : sum[CHAN_W-1:0];
    end

endmodule

### hw/rtl/apbc_blend.sv
// apbc_blend: mode select and special cases around four over channels.
// Depends on apbc_pkg and apbc_over_chan.

module apbc_blend import apbc_pkg::*; (
    input  blend_mode_t      mode,
    input  logic [PIX_W-1:0] src_pixel,
    input  logic [PIX_W-1:0] dst_pixel,
    output blend_res_t       res
);

    logic [CHAN_W-1:0] inv_alpha;
    logic [PIX_W-1:0]  over_pix;

    assign inv_alpha = CHAN_MAX - src_pixel[PIX_W-1 -: CHAN_W];

    for (genvar i = 0; i < NUM_CH; i++)
    begin : g_chan
        apbc_over_chan u_chan (
            .src_c     (src_pixel[i*CHAN_W +: CHAN_W]),
            .dst_c     (dst_pixel[i*CHAN_W +: CHAN_W]),
            .inv_alpha (inv_alpha),
            .res_c     (over_pix[i*CHAN_W +: CHAN_W])
        );
    end

    always_comb
    begin
        res.pixel        = src_pixel;
        res.write_enable = 1'b1;
        case (mode)
            MODE_COPY:  res.pixel = src_pixel;
            MODE_RGB:   res.pixel = (src_pixel & RGB_MASK) | (dst_pixel & ALPHA_MASK);
            MODE_ALPHA: res.pixel = (src_pixel & ALPHA_MASK) | (dst_pixel & RGB_MASK);
            MODE_OVER:
            begin
                if (src_pixel[PIX_W-1 -: CHAN_W] == CHAN_MAX)
                begin
                    res.pixel = src_pixel;  // opaque source
                end
                else if (src_pixel == '0)
                begin
                    res.pixel        = dst_pixel;  // fully transparent: skip write
                    res.write_enable = 1'b0;
                end
                else
                begin
                    res.pixel = over_pix;
                end
            end
            default:    res.pixel = src_pixel;
        endcase
    end

endmodule

### hw/rtl/argb_pixel_blit_compositor_unit.sv
// argb_pixel_blit_compositor_unit: top level of the ARGB8888 blit compositor.
// Depends on apbc_pkg, apbc_if (request/response interfaces) and apbc_blend.
//
// Usage:
//   req_ch carries one request per pixel: src_pixel and dst_pixel, ARGB8888.
//   rsp_ch returns one response per request, in order: out_pixel and
//   write_enable (0 means leave the destination untouched).
//   cfg_we/cfg_wdata load the 2-bit blend mode (copy, rgb keeping dst
//   alpha, alpha only, premultiplied over); change it only while idle.
// Timing:
//   Two register stages: an input register, the blend logic, then the
//   response register. A request waits in the input register until the
//   response register is free. One pixel per cycle while rsp_ch.ready is
//   high; the single 8x8 multiply per channel sits between the registers.
// Reset:
//   rst_n clears both stage valids and sets the mode to copy.
// Backpressure:
//   When rsp_ch.ready is low the response register holds; the input stage
//   still takes a request if it is empty, then req_ch.ready drops until the
//   response drains. No request is dropped or duplicated.

module argb_pixel_blit_compositor_unit import apbc_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    apbc_req_if.sink          req_ch,
    apbc_rsp_if.source        rsp_ch,
    input  logic              cfg_we,
    input  logic [MODE_W-1:0] cfg_wdata
);

    blend_mode_t      mode_reg;

    // input stage
    logic             s1_valid_reg;
    logic [PIX_W-1:0] s1_src_reg;
    logic [PIX_W-1:0] s1_dst_reg;

    // response stage
    logic             out_valid_reg;
    logic [PIX_W-1:0] out_pixel_reg;
    logic             out_we_reg;

    logic             out_load;
    logic             s1_load;
    blend_res_t       blend_res;

    // response register frees up when empty or being taken this cycle
    assign out_load     = !out_valid_reg || rsp_ch.ready;
    assign req_ch.ready = !s1_valid_reg || out_load;
    assign s1_load      = req_ch.valid && req_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_COPY;
        end
        else if (cfg_we)
        begin
            mode_reg <= blend_mode_t'(cfg_wdata);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_ch.ready)
            begin
                s1_valid_reg <= req_ch.valid;
            end
            if (out_load)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_src_reg <= req_ch.src_pixel;
            s1_dst_reg <= req_ch.dst_pixel;
        end
        if (out_load && s1_valid_reg)
        begin
            out_pixel_reg <= blend_res.pixel;
            out_we_reg    <= blend_res.write_enable;
        end
    end

    apbc_blend u_blend (
        .mode      (mode_reg),
        .src_pixel (s1_src_reg),
        .dst_pixel (s1_dst_reg),
        .res       (blend_res)
    );

    assign rsp_ch.valid        = out_valid_reg;
    assign rsp_ch.out_pixel    = out_pixel_reg;
    assign rsp_ch.write_enable = out_we_reg;

endmodule
